// ----- hdl/mfsd_pkg.sv -----
package mfsd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int ERR_W   = 24;
    localparam int SPD_W   = 24;
    localparam int CUR_W   = 16;
    localparam int ANG_W   = 32;
    localparam int RUN_W   = 8;
    localparam int HOLD_W  = 16;
    localparam int WIN_W   = 16;
    localparam int PCT_W   = 7;
    localparam int LIM_W   = 23;
    localparam int CMIN_W  = 15;
    localparam int PROG_W  = 24;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 24;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_RST    = 16'd200;
    localparam logic [LIM_W-1:0]  ERR_LIM_RST = 23'd16;
    localparam logic [LIM_W-1:0]  SPD_LIM_RST = 23'd160;
    localparam logic [CMIN_W-1:0] CUR_MIN_RST = 15'd3000;
    localparam logic [WIN_W-1:0]  WIN_LEN_RST = 16'd100;
    localparam logic [PCT_W-1:0]  PCT_RST     = 7'd80;
    localparam logic [PROG_W-1:0] PROG_RST    = 24'd80;
    localparam logic [RUN_W-1:0]  CONFIRM_RST = 8'd3;

    localparam logic [RUN_W-1:0]  RUN_MAX     = 8'd255;
    localparam int                PERCENT_FULL = 100;

    typedef enum logic [CFG_AW-1:0] {
        CFG_HOLD    = 3'd0,
        CFG_ERR_LIM = 3'd1,
        CFG_SPD_LIM = 3'd2,
        CFG_CUR_MIN = 3'd3,
        CFG_WIN_LEN = 3'd4,
        CFG_PCT     = 3'd5,
        CFG_PROG    = 3'd6,
        CFG_CONFIRM = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [HOLD_W-1:0] startup_hold_ticks;
        logic [LIM_W-1:0]  finish_error_limit;
        logic [LIM_W-1:0]  finish_speed_limit;
        logic [CMIN_W-1:0] effort_current_min;
        logic [WIN_W-1:0]  window_length;
        logic [PCT_W-1:0]  effort_percent;
        logic [PROG_W-1:0] progress_max;
        logic [RUN_W-1:0]  confirm_windows;
    } cfg_t;

    typedef struct packed {
        logic             begin_motion;
        logic [ERR_W-1:0] position_error;
        logic [SPD_W-1:0] motor_speed;
        logic [CUR_W-1:0] command_current;
        logic [CUR_W-1:0] measured_current;
        logic [ANG_W-1:0] motor_angle;
        logic             ascending;
    } item_t;

    typedef struct packed {
        logic             stall_res;
        logic             window_closed;
        logic [RUN_W-1:0] stalled_windows;
    } res_t;

endpackage

// ----- hdl/mfsd_track.sv -----
module mfsd_track #(
    parameter int COUNT_WIDTH = mfsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    input  mfsd_pkg::item_t item,
    input  mfsd_pkg::cfg_t  cfg,
    output mfsd_pkg::res_t  res
);

    localparam int CW = COUNT_WIDTH;
    localparam int PW = (CW > mfsd_pkg::WIN_W) ? CW : mfsd_pkg::WIN_W;
    localparam int MW = CW + mfsd_pkg::PCT_W;
    localparam int AW = mfsd_pkg::ANG_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic [mfsd_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic [CW-1:0]               tick_reg, tick_next;
    logic [CW-1:0]               effort_reg, effort_next;
    logic [AW-1:0]               start_reg, start_next;
    logic [mfsd_pkg::RUN_W-1:0]  run_reg, run_next;

    logic [mfsd_pkg::ERR_W-1:0] err_mag;
    logic [mfsd_pkg::SPD_W-1:0] spd_mag;
    logic [mfsd_pkg::CUR_W-1:0] cmd_mag, meas_mag;
    logic                       finished, high_cur, closes, effort_ok, progress_ok;
    logic [CW-1:0]              tick_inc, effort_inc;
    logic [MW-1:0]              prod_e, prod_t;
    logic signed [AW:0]         diff;
    logic signed [AW+1:0]       progress, prog_lim;
    logic [mfsd_pkg::RUN_W-1:0] run_inc;

    always_comb begin
        err_mag  = item.position_error[mfsd_pkg::ERR_W-1]
                 ? (~item.position_error + 1'b1) : item.position_error;
        spd_mag  = item.motor_speed[mfsd_pkg::SPD_W-1]
                 ? (~item.motor_speed + 1'b1) : item.motor_speed;
        cmd_mag  = item.command_current[mfsd_pkg::CUR_W-1]
                 ? (~item.command_current + 1'b1) : item.command_current;
        meas_mag = item.measured_current[mfsd_pkg::CUR_W-1]
                 ? (~item.measured_current + 1'b1) : item.measured_current;

        finished = (err_mag <= {1'b0, cfg.finish_error_limit})
                && (spd_mag <= {1'b0, cfg.finish_speed_limit});
        high_cur = (cmd_mag >= {1'b0, cfg.effort_current_min})
                || (meas_mag >= {1'b0, cfg.effort_current_min});

        tick_inc   = (tick_reg != CNT_MAX) ? tick_reg + 1'b1 : tick_reg;
        effort_inc = (high_cur && effort_reg != CNT_MAX) ? effort_reg + 1'b1 : effort_reg;
        closes     = PW'(tick_inc) >= PW'(cfg.window_length);

        prod_e    = {{mfsd_pkg::PCT_W{1'b0}}, effort_inc} * MW'(mfsd_pkg::PERCENT_FULL);
        prod_t    = {{mfsd_pkg::PCT_W{1'b0}}, tick_inc} * {{CW{1'b0}}, cfg.effort_percent};
        effort_ok = prod_e >= prod_t;

        diff     = $signed({item.motor_angle[AW-1], item.motor_angle})
                 - $signed({start_reg[AW-1], start_reg});
        progress = item.ascending ? -$signed({diff[AW], diff}) : $signed({diff[AW], diff});
        prog_lim = $signed({{(AW + 2 - mfsd_pkg::PROG_W){cfg.progress_max[mfsd_pkg::PROG_W-1]}},
                            cfg.progress_max});
        progress_ok = progress <= prog_lim;

        run_inc = (run_reg != mfsd_pkg::RUN_MAX) ? run_reg + 1'b1 : run_reg;
    end

    always_comb begin
        hold_next   = hold_reg;
        tick_next   = tick_reg;
        effort_next = effort_reg;
        start_next  = start_reg;
        run_next    = run_reg;
        res         = '0;
        if (item.begin_motion) begin
            hold_next   = cfg.startup_hold_ticks;
            tick_next   = '0;
            effort_next = '0;
            start_next  = item.motor_angle;
            run_next    = '0;
        end else if (hold_reg != '0) begin
            hold_next   = hold_reg - 1'b1;
            tick_next   = '0;
            effort_next = '0;
            start_next  = item.motor_angle;
            run_next    = '0;
        end else if (finished) begin
            tick_next   = '0;
            effort_next = '0;
            start_next  = item.motor_angle;
            run_next    = '0;
        end else begin
            tick_next   = tick_inc;
            effort_next = effort_inc;
            if (closes) begin
                run_next          = (effort_ok && progress_ok) ? run_inc : '0;
                res.stall_res     = run_next >= cfg.confirm_windows;
                res.window_closed = 1'b1;
                tick_next         = '0;
                effort_next       = '0;
                start_next        = item.motor_angle;
            end
            res.stalled_windows = run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg   <= '0;
            tick_reg   <= '0;
            effort_reg <= '0;
            start_reg  <= '0;
            run_reg    <= '0;
        end else if (item_valid) begin
            hold_reg   <= hold_next;
            tick_reg   <= tick_next;
            effort_reg <= effort_next;
            start_reg  <= start_next;
            run_reg    <= run_next;
        end
    end

endmodule

// ----- hdl/motor_fast_stall_detector_core.sv -----
// Each accepted input word yields a registered result word, presented on m_tvalid.
// Throughput: one word per cycle while s_tready is high; the tracking counters update
// in the accepting cycle. A two-entry output buffer (register plus skid) lets input
// flow while a result waits; s_tready drops only when both entries hold untaken results.
// Reset (aresetn low, synchronous): registers take their defaults, counters and the
// stall run clear to zero, and the output buffer empties.
module motor_fast_stall_detector_core #(
    parameter int COUNT_WIDTH = mfsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // position_error[23:0], motor_speed[47:24], command_current[63:48],
    // measured_current[79:64], motor_angle[111:80], ascending[112], zero fill
    input  logic [mfsd_pkg::S_TDATA_W-1:0] s_tdata,
    // begin_motion[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // stall_res[0], window_closed[1], stalled_windows[9:2], zero fill
    output logic [mfsd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mfsd_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [mfsd_pkg::CFG_DW-1:0]    cfg_data
);

    mfsd_pkg::cfg_t  cfg_reg;
    mfsd_pkg::item_t item;
    mfsd_pkg::res_t  res;
    mfsd_pkg::res_t  out_reg, out_next, skid_reg, skid_next;
    logic            out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic            in_accept, out_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.startup_hold_ticks <= mfsd_pkg::HOLD_RST;
            cfg_reg.finish_error_limit <= mfsd_pkg::ERR_LIM_RST;
            cfg_reg.finish_speed_limit <= mfsd_pkg::SPD_LIM_RST;
            cfg_reg.effort_current_min <= mfsd_pkg::CUR_MIN_RST;
            cfg_reg.window_length      <= mfsd_pkg::WIN_LEN_RST;
            cfg_reg.effort_percent     <= mfsd_pkg::PCT_RST;
            cfg_reg.progress_max       <= mfsd_pkg::PROG_RST;
            cfg_reg.confirm_windows    <= mfsd_pkg::CONFIRM_RST;
        end else if (cfg_valid) begin
            unique case (mfsd_pkg::cfg_idx_t'(cfg_addr))
                mfsd_pkg::CFG_HOLD:    cfg_reg.startup_hold_ticks <= cfg_data[15:0];
                mfsd_pkg::CFG_ERR_LIM: cfg_reg.finish_error_limit <= cfg_data[22:0];
                mfsd_pkg::CFG_SPD_LIM: cfg_reg.finish_speed_limit <= cfg_data[22:0];
                mfsd_pkg::CFG_CUR_MIN: cfg_reg.effort_current_min <= cfg_data[14:0];
                mfsd_pkg::CFG_WIN_LEN: cfg_reg.window_length      <= cfg_data[15:0];
                mfsd_pkg::CFG_PCT:     cfg_reg.effort_percent     <= cfg_data[6:0];
                mfsd_pkg::CFG_PROG:    cfg_reg.progress_max       <= cfg_data[23:0];
                mfsd_pkg::CFG_CONFIRM: cfg_reg.confirm_windows    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        item.begin_motion     = s_tuser;
        item.position_error   = s_tdata[23:0];
        item.motor_speed      = s_tdata[47:24];
        item.command_current  = s_tdata[63:48];
        item.measured_current = s_tdata[79:64];
        item.motor_angle      = s_tdata[111:80];
        item.ascending        = s_tdata[112];
    end

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;

    mfsd_track #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(in_accept),
        .item      (item),
        .cfg       (cfg_reg),
        .res       (res)
    );

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_accept) begin
            if (!out_valid_reg || out_take) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.stalled_windows, out_reg.window_closed, out_reg.stall_res};

endmodule

// ----- verif/mfsd_stall_check.sv -----
`timescale 1ns / 1ps
module mfsd_stall_check
    import mfsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_AW-1:0]      cfg_addr,
    input  logic [CFG_DW-1:0]      cfg_data,
    output int                     mismatches,
    output int                     pending
);

    cfg_t                       knobs;
    logic [HOLD_W-1:0]          holdoff_left;
    logic [COUNT_WIDTH_DEF-1:0] tick_cnt;
    logic [COUNT_WIDTH_DEF-1:0] effort_cnt;
    logic [ANG_W-1:0]           window_angle;
    logic [RUN_W-1:0]           run_len;
    res_t                       expected_flags[$];

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic restart_window(input logic [ANG_W-1:0] angle, input bit drop_run);
        tick_cnt     = '0;
        effort_cnt   = '0;
        window_angle = angle;
        if (drop_run) begin
            run_len = '0;
        end
    endtask

    task automatic track_window(input item_t it, output res_t r);
        longint err;
        longint spd;
        longint cmd;
        longint meas;
        longint progress;
        bit     busy;
        bit     enough;
        err  = longint'($signed(it.position_error));
        spd  = longint'($signed(it.motor_speed));
        cmd  = longint'($signed(it.command_current));
        meas = longint'($signed(it.measured_current));
        r    = '0;
        if (it.begin_motion) begin
            holdoff_left = knobs.startup_hold_ticks;
            restart_window(it.motor_angle, 1'b1);
        end else if (holdoff_left != '0) begin
            holdoff_left--;
            restart_window(it.motor_angle, 1'b1);
        end else if (magnitude(err) <= longint'(knobs.finish_error_limit) &&
                     magnitude(spd) <= longint'(knobs.finish_speed_limit)) begin
            restart_window(it.motor_angle, 1'b1);
        end else begin
            if (tick_cnt != '1) begin
                tick_cnt++;
            end
            busy = magnitude(cmd) >= longint'(knobs.effort_current_min) ||
                   magnitude(meas) >= longint'(knobs.effort_current_min);
            if (busy && effort_cnt != '1) begin
                effort_cnt++;
            end
            if (longint'(tick_cnt) >= longint'(knobs.window_length)) begin
                progress = longint'($signed(it.motor_angle)) - longint'($signed(window_angle));
                if (it.ascending) begin
                    progress = -progress;
                end
                enough = longint'(effort_cnt) * PERCENT_FULL >=
                         longint'(tick_cnt) * longint'(knobs.effort_percent);
                if (enough && progress <= longint'($signed(knobs.progress_max))) begin
                    if (run_len != RUN_MAX) begin
                        run_len++;
                    end
                end else begin
                    run_len = '0;
                end
                r.stall_res     = (run_len >= knobs.confirm_windows);
                r.window_closed = 1'b1;
                restart_window(it.motor_angle, 1'b0);
            end
        end
        r.stalled_windows = run_len;
    endtask

    always @(posedge aclk) begin
        item_t it;
        res_t  want;
        res_t  got;
        if (!aresetn) begin
            knobs = '{HOLD_RST, ERR_LIM_RST, SPD_LIM_RST, CUR_MIN_RST,
                      WIN_LEN_RST, PCT_RST, PROG_RST, CONFIRM_RST};
            holdoff_left = '0;
            restart_window('0, 1'b1);
            expected_flags.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_HOLD:    knobs.startup_hold_ticks = cfg_data[HOLD_W-1:0];
                    CFG_ERR_LIM: knobs.finish_error_limit = cfg_data[LIM_W-1:0];
                    CFG_SPD_LIM: knobs.finish_speed_limit = cfg_data[LIM_W-1:0];
                    CFG_CUR_MIN: knobs.effort_current_min = cfg_data[CMIN_W-1:0];
                    CFG_WIN_LEN: knobs.window_length      = cfg_data[WIN_W-1:0];
                    CFG_PCT:     knobs.effort_percent     = cfg_data[PCT_W-1:0];
                    CFG_PROG:    knobs.progress_max       = cfg_data[PROG_W-1:0];
                    CFG_CONFIRM: knobs.confirm_windows    = cfg_data[RUN_W-1:0];
                    default: ;
                endcase
            end
            // results are registered and never leave in the cycle their input is taken, so take them before new input
            if (m_tvalid && m_tready) begin
                got.stall_res       = m_tdata[0];
                got.window_closed   = m_tdata[1];
                got.stalled_windows = m_tdata[9:2];
                if (expected_flags.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result word stall=%0d closed=%0d run=%0d",
                                 $realtime, got.stall_res, got.window_closed,
                                 got.stalled_windows);
                    end
                    mismatches++;
                end else begin
                    want = expected_flags.pop_front();
                    if (got.stall_res !== want.stall_res ||
                        got.window_closed !== want.window_closed ||
                        got.stalled_windows !== want.stalled_windows) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch exp stall=%0d closed=%0d run=%0d, got stall=%0d closed=%0d run=%0d",
                                     $realtime, want.stall_res, want.window_closed,
                                     want.stalled_windows, got.stall_res,
                                     got.window_closed, got.stalled_windows);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                it.begin_motion     = s_tuser;
                it.position_error   = s_tdata[23:0];
                it.motor_speed      = s_tdata[47:24];
                it.command_current  = s_tdata[63:48];
                it.measured_current = s_tdata[79:64];
                it.motor_angle      = s_tdata[111:80];
                it.ascending        = s_tdata[112];
                track_window(it, want);
                expected_flags.push_back(want);
            end
        end
        pending = expected_flags.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import mfsd_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_DW-1:0]    cfg_data;

    int   mismatches;
    int   pending;
    int   send_gap_pct;
    int   stall_pct;
    int   hold_req;
    int   words_sent;
    cfg_t knobs;

    motor_fast_stall_detector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    mfsd_stall_check stall_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_tick(input bit start_flag, input logic [23:0] err,
                             input logic [23:0] spd, input logic [15:0] cmd,
                             input logic [15:0] meas, input logic [31:0] ang,
                             input bit asc);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start_flag;
        s_tdata  <= {7'd0, asc, ang, meas, cmd, spd, err};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic noise_tick();
        send_tick($urandom_range(4) == 0, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom_range(1));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic set_all(input cfg_t c);
        settle();
        knobs = c;
        write_reg(CFG_HOLD, c.startup_hold_ticks);
        write_reg(CFG_ERR_LIM, c.finish_error_limit);
        write_reg(CFG_SPD_LIM, c.finish_speed_limit);
        write_reg(CFG_CUR_MIN, c.effort_current_min);
        write_reg(CFG_WIN_LEN, c.window_length);
        write_reg(CFG_PCT, c.effort_percent);
        write_reg(CFG_PROG, c.progress_max);
        write_reg(CFG_CONFIRM, c.confirm_windows);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] outside_limit(int unsigned lim);
        int v;
        if (lim >= 24'h7FFFFF) begin
            return 24'h800000;
        end
        v = $urandom_range(lim + 1, 24'h7FFFFF);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic [23:0] within_limit(int unsigned lim);
        int v;
        v = $urandom_range(0, lim);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic [15:0] current_word(bit heavy, int unsigned cmin);
        int v;
        if (heavy) begin
            if ($urandom_range(15) == 0) begin
                return 16'h8000;
            end
            v = $urandom_range(cmin, 32767);
        end else if (cmin == 0) begin
            v = 0;
        end else begin
            v = $urandom_range(0, cmin - 1);
        end
        return $urandom_range(1) ? -v : v;
    endfunction

    // mode 0: random, 1: all low extremes, 2: all high extremes
    function automatic cfg_t roll_knobs(int mode);
        cfg_t c;
        int   r;
        if (mode == 1) begin
            return '{16'd0, 23'd0, 23'd0, 15'd0, 16'd0, 7'd0, 24'h800000, 8'd0};
        end
        if (mode == 2) begin
            return '{16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 15'h7FFF, 16'hFFFF, 7'd127,
                     24'h7FFFFF, 8'd255};
        end
        c.startup_hold_ticks = $urandom_range(0, 6);
        r = $urandom_range(99);
        c.finish_error_limit = (r < 70) ? $urandom_range(0, 300) : (r < 85) ? 0 : 23'h7FFFFF;
        r = $urandom_range(99);
        c.finish_speed_limit = (r < 70) ? $urandom_range(0, 300) : (r < 85) ? 0 : 23'h7FFFFF;
        r = $urandom_range(99);
        c.effort_current_min = (r < 60) ? $urandom_range(500, 6000) : (r < 80) ? 0 : 15'h7FFF;
        r = $urandom_range(99);
        c.window_length = (r < 60) ? $urandom_range(1, 8) : (r < 75) ? 0 :
                          (r < 90) ? $urandom_range(9, 40) : 16'hFFFF;
        r = $urandom_range(99);
        c.effort_percent = (r < 60) ? $urandom_range(0, 100) : (r < 75) ? 0 :
                           (r < 90) ? 100 : $urandom_range(101, 127);
        r = $urandom_range(99);
        c.progress_max = (r < 60) ? $urandom_range(0, 250) - 50 :
                         (r < 80) ? 24'h800000 : 24'h7FFFFF;
        r = $urandom_range(99);
        c.confirm_windows = (r < 60) ? $urandom_range(1, 4) : (r < 75) ? 0 :
                            (r < 90) ? 255 : $urandom_range(5, 254);
        return c;
    endfunction

    // one motion: start word, hold-off words, then moving words around a slowly
    // drifting angle, with some finished and garbage words mixed in
    task automatic motion_run(input int moves);
        logic [31:0] ang;
        bit          asc;
        bit          heavy;
        bit          pick;
        int          drift;
        int          heavy_pct;
        int          holds;
        int          r;
        ang       = $urandom;
        asc       = $urandom_range(1);
        heavy_pct = $urandom_range(60, 100);
        case ($urandom_range(3))
            0:       drift = 0;
            1:       drift = 4;
            2:       drift = 40;
            default: drift = 4000;
        endcase
        send_tick(1'b1, $urandom, $urandom, $urandom, $urandom, ang, asc);
        holds = (knobs.startup_hold_ticks <= 8) ? knobs.startup_hold_ticks :
                $urandom_range(1, 4);
        repeat (holds) send_tick(1'b0, $urandom, $urandom, $urandom, $urandom, ang, asc);
        repeat (moves) begin
            ang = ang + ($urandom_range(0, 2 * drift) - drift);
            r   = $urandom_range(99);
            if (r < 6) begin
                send_tick(1'b0, within_limit(knobs.finish_error_limit),
                          within_limit(knobs.finish_speed_limit), $urandom, $urandom,
                          ang, asc);
            end else if (r < 10) begin
                noise_tick();
            end else begin
                heavy = ($urandom_range(99) < heavy_pct);
                pick  = $urandom_range(1);
                if ($urandom_range(1)) begin
                    send_tick(1'b0, outside_limit(knobs.finish_error_limit), $urandom,
                              current_word(heavy && pick, knobs.effort_current_min),
                              current_word(heavy && !pick, knobs.effort_current_min),
                              ang, asc);
                end else begin
                    send_tick(1'b0, within_limit(knobs.finish_error_limit),
                              outside_limit(knobs.finish_speed_limit),
                              current_word(heavy && pick, knobs.effort_current_min),
                              current_word(heavy && !pick, knobs.effort_current_min),
                              ang, asc);
                end
            end
        end
    endtask

    initial begin
        int   mode;
        int   target;
        cfg_t edge_knobs;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_addr     = '0;
        cfg_data     = '0;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_req     = 0;
        words_sent   = 0;
        knobs = '{HOLD_RST, ERR_LIM_RST, SPD_LIM_RST, CUR_MIN_RST,
                  WIN_LEN_RST, PCT_RST, PROG_RST, CONFIRM_RST};
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: start word and a hold-off word at field extremes
        send_tick(1'b1, 24'h7FFFFF, 24'h800000, 16'h8000, 16'h7FFF, 32'h80000000, 1'b1);
        send_tick(1'b0, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h8000, 32'h7FFFFFFF, 1'b0);

        // short windows, limit boundaries, both directions
        set_all('{16'd1, 23'd16, 23'd160, 15'd3000, 16'd2, 7'd50, 24'd80, 8'd1});
        send_tick(1'b1, 24'd0, 24'd0, 16'd0, 16'd0, 32'd0, 1'b0);
        send_tick(1'b0, 24'd5000, 24'd0, 16'd0, 16'd0, 32'd0, 1'b0);
        send_tick(1'b0, 24'd16, 24'hFFFF60, 16'd0, 16'd0, 32'd0, 1'b0);
        send_tick(1'b0, 24'd17, 24'd0, -16'sd3000, 16'd0, 32'd40, 1'b0);
        send_tick(1'b0, -24'sd17, 24'd0, 16'd0, 16'd2999, 32'd80, 1'b0);
        send_tick(1'b0, 24'd17, 24'd161, 16'd0, 16'd0, 32'd81, 1'b0);
        send_tick(1'b0, 24'd17, 24'd0, 16'd3000, 16'd0, 32'd161, 1'b0);
        send_tick(1'b0, 24'd17, 24'd0, 16'd3000, 16'd0, 32'd100, 1'b1);
        send_tick(1'b0, 24'd17, 24'd0, 16'd3000, 16'd0, 32'd0, 1'b1);

        // zero window, zero confirm, unreachable percent, angle wrap
        edge_knobs = roll_knobs(1);
        edge_knobs.effort_percent = 7'd127;
        set_all(edge_knobs);
        send_tick(1'b1, 24'd0, 24'd0, 16'd0, 16'd0, 32'h80000000, 1'b0);
        send_tick(1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 32'h12345678, 1'b0);
        send_tick(1'b0, 24'd1, 24'd0, 16'd0, 16'd0, 32'h7FFFFFFF, 1'b0);
        send_tick(1'b0, 24'd0, 24'h800000, 16'd0, 16'd0, 32'h80000000, 1'b1);

        // widest limits: only the most negative error or speed counts as moving
        set_all('{16'd0, 23'h7FFFFF, 23'h7FFFFF, 15'h7FFF, 16'd1, 7'd0, 24'h7FFFFF, 8'd255});
        send_tick(1'b0, 24'h800000, 24'd0, 16'h8000, 16'd0, 32'h80000000, 1'b0);
        send_tick(1'b0, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h8000, 32'd0, 1'b0);

        for (int p = 0; p < 14; p++) begin
            mode = (p == 5) ? 1 : (p == 9) ? 2 : 0;
            set_all(roll_knobs(mode));
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 57; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 57; end
                default: begin send_gap_pct = 26; stall_pct = 26; end
            endcase
            if (p == 4) begin
                hold_req = 90;
            end
            target = words_sent + ((mode == 2) ? 30 : 90);
            while (words_sent < target) begin
                if ($urandom_range(99) < 12) begin
                    repeat ($urandom_range(1, 4)) noise_tick();
                end else begin
                    motion_run($urandom_range(4, 60));
                end
            end
        end

        // long stalled run so the run counter saturates
        set_all('{16'd0, 23'd0, 23'd0, 15'd0, 16'd1, 7'd0, 24'h7FFFFF, 8'd255});
        send_gap_pct = 26;
        stall_pct    = 26;
        send_tick(1'b1, $urandom, $urandom, $urandom, $urandom, 32'd1000, 1'b0);
        repeat (300) send_tick(1'b0, outside_limit(0), $urandom, $urandom, $urandom,
                               32'd1000, 1'b0);

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- motor_fast_stall_detector_core.f -----
hdl/mfsd_pkg.sv
hdl/mfsd_track.sv
hdl/motor_fast_stall_detector_core.sv
verif/mfsd_stall_check.sv
verif/tb_top.sv
